// ----- hdl/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
// No dependencies; imported by every module under hdl/.
package bcc_pkg;

  localparam int unsigned MAX_BUTTONS = 3;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned HOLD_W      = 8;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 8'd6;
  localparam logic [APB_AW-1:0] ADDR_HOLD_TICKS = 3'd0;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_HOLD   = 2'd3
  } click_ev_e;

  typedef struct packed {
    logic adv;
    logic pressed;
  } bcc_lane_in_t;

endpackage

// ----- hdl/button_click_classifier_core.sv -----
// Top level of the button click classifier: input register, per-button lanes,
// result register and APB-style config port. Depends on bcc_pkg, bcc_cfg, bcc_lane.
//
// Each transaction on the input channel is one scan tick carrying the
// active-low levels of up to three buttons (BUTTONS, 1 to 3). Every tick
// yields exactly one result transaction with a 2-bit event per button
// (none, single, double, hold); buttons at or above BUTTONS always report
// none. A tick is captured in the input register, the lane state machines
// advance when it moves into the result register, which drives the outputs.
// One tick is accepted per cycle while in_stall_o is low; throughput is set
// only by out_stall_i. hold_ticks (offset 0x0, reset 6) reloads the
// per-button window on each press; write it only while no tick is in flight.
module button_click_classifier_core
  import bcc_pkg::*;
#(
  parameter int unsigned BUTTONS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [LEVEL_W-1:0] levels_n_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         click_btn0_o,
  output logic [1:0]         click_btn1_o,
  output logic [1:0]         click_btn2_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic               in_valid_q;
  logic [LEVEL_W-1:0] levels_q;
  logic               out_valid_q;
  click_ev_e          ev_q [MAX_BUTTONS];
  click_ev_e          ev   [MAX_BUTTONS];
  logic               out_free, fire;
  logic [HOLD_W-1:0]  hold_ticks;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  bcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .hold_ticks_o(hold_ticks)
  );

  for (genvar k = 0; k < MAX_BUTTONS; k++) begin : g_btn
    if (k < BUTTONS) begin : g_lane
      bcc_lane_in_t ctl;
      assign ctl.adv     = fire;
      assign ctl.pressed = !levels_q[k];
      bcc_lane u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .hold_ticks_i(hold_ticks),
        .ev_o        (ev[k])
      );
    end else begin : g_off
      assign ev[k] = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) levels_q <= levels_n_i;
    if (fire) begin
      for (int k = 0; k < MAX_BUTTONS; k++) ev_q[k] <= ev[k];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign click_btn0_o = ev_q[0];
  assign click_btn1_o = ev_q[1];
  assign click_btn2_o = ev_q[2];

  property p_stall_needs_tick;
    @(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> (in_valid_q && out_valid_q);
  endproperty
  a_stall_needs_tick: assert property (p_stall_needs_tick)
    else $error("core: input stalled with no tick held");

  property p_fire_gives_result;
    @(posedge clk_i) disable iff (!rst_ni)
      fire |=> out_valid_q;
  endproperty
  a_fire_gives_result: assert property (p_fire_gives_result)
    else $error("core: tick advanced without a result");

  property p_unused_quiet;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && (BUTTONS < MAX_BUTTONS)) |-> (click_btn2_o == EV_NONE);
  endproperty
  a_unused_quiet: assert property (p_unused_quiet)
    else $error("core: unscanned button reported an event");

endmodule

// ----- hdl/bcc_cfg.sv -----
// APB-style register file holding hold_ticks.
// Depends on bcc_pkg.
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [HOLD_W-1:0] hold_ticks_o
);

  logic [HOLD_W-1:0] hold_ticks_q;
  logic              hit;
  logic              wr_en;

  // word-aligned decode: byte offset bits ignored
  assign hit    = (paddr[APB_AW-1:2] == ADDR_HOLD_TICKS[APB_AW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_TICKS_RST;
    end else if (wr_en) begin
      hold_ticks_q <= pwdata[HOLD_W-1:0];
    end
  end

  assign prdata       = hit ? {{(APB_DW-HOLD_W){1'b0}}, hold_ticks_q} : '0;
  assign hold_ticks_o = hold_ticks_q;

endmodule

// ----- hdl/bcc_lane.sv -----
// Per-button click state machine with its window countdown.
// Depends on bcc_pkg.
module bcc_lane
  import bcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcc_lane_in_t      ctl_i,
  input  logic [HOLD_W-1:0] hold_ticks_i,
  output click_ev_e         ev_o
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESS1   = 3'd1,
    PH_RELEASE1 = 3'd2,
    PH_PRESS2   = 3'd3,
    PH_HOLD     = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [HOLD_W-1:0] count_q, count_d, count_dec;
  logic              expired;
  click_ev_e         ev;

  assign count_dec = (count_q != '0) ? count_q - 1'b1 : count_q;
  assign expired   = (count_dec == '0);

  // timeout check first, level check second
  always_comb begin
    phase_d = phase_q;
    count_d = count_dec;
    ev      = EV_NONE;
    unique case (phase_q)
      PH_IDLE: begin
        if (ctl_i.pressed) begin
          count_d = hold_ticks_i;
          phase_d = PH_PRESS1;
        end
      end
      PH_PRESS1: begin
        if (expired) phase_d = PH_HOLD;
        if (!ctl_i.pressed) phase_d = PH_RELEASE1;
      end
      PH_RELEASE1: begin
        if (expired) begin
          ev      = EV_SINGLE;
          phase_d = PH_IDLE;
        end
        if (ctl_i.pressed) begin
          count_d = hold_ticks_i;
          phase_d = PH_PRESS2;
        end
      end
      PH_PRESS2: begin
        if (expired) phase_d = PH_HOLD;
        if (!ctl_i.pressed) begin
          ev      = EV_DOUBLE;
          phase_d = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (!ctl_i.pressed) begin
          ev      = EV_HOLD;
          phase_d = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (ctl_i.adv) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign ev_o = ev;

  // a single click may coincide with a new press that opens the second window
  property p_event_ends_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      (ctl_i.adv && (ev != EV_NONE))
        |=> ((phase_q == PH_IDLE) || (phase_q == PH_PRESS2));
  endproperty
  a_event_ends_idle: assert property (p_event_ends_idle)
    else $error("lane: event reported without return to idle");

  property p_idle_press_reload;
    @(posedge clk_i) disable iff (!rst_ni)
      (ctl_i.adv && (phase_q == PH_IDLE) && ctl_i.pressed)
        |=> (count_q == $past(hold_ticks_i)) && (phase_q == PH_PRESS1);
  endproperty
  a_idle_press_reload: assert property (p_idle_press_reload)
    else $error("lane: press from idle did not load window");

  property p_hold_no_count;
    @(posedge clk_i) disable iff (!rst_ni)
      (phase_q == PH_HOLD) |-> (count_q == '0);
  endproperty
  a_hold_no_count: assert property (p_hold_no_count)
    else $error("lane: hold phase with window still running");

endmodule

// ----- tb/button_click_classifier_core_tb.sv -----
// Self-checking testbench for button_click_classifier_core: random scan ticks with idle and
// stall, per-button click prediction, and hold_ticks written over APB between phases.
// Depends on bcc_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module button_click_classifier_core_tb;
  import bcc_pkg::*;

  localparam int unsigned N_BUTTONS = 3;
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESS1   = 3'd1,
    ST_RELEASE1 = 3'd2,
    ST_PRESS2   = 3'd3,
    ST_HOLD     = 3'd4
  } click_phase_e;

  typedef logic [2*MAX_BUTTONS-1:0] click_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [LEVEL_W-1:0] levels_n_i = '1;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] click_btn0_o, click_btn1_o, click_btn2_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  logic [LEVEL_W-1:0] tick_queue [$];
  click_row_t clicks_due [$];
  logic [HOLD_W-1:0] hold_cfg;
  click_phase_e phase_q [MAX_BUTTONS];
  logic [HOLD_W-1:0] window_q [MAX_BUTTONS];
  logic calm = 1'b0;
  int errors = 0;
  int ticks_sent = 0;
  int settings_run = 0;
  int ev_seen [4];

  button_click_classifier_core #(.BUTTONS(N_BUTTONS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .levels_n_i,
    .out_valid_o, .out_stall_i, .click_btn0_o, .click_btn1_o, .click_btn2_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #(20 * 400000);
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic click_row_t classify_tick(input logic [LEVEL_W-1:0] lv);
    click_row_t row;
    click_ev_e ev;
    logic pressed, expired;
    int k;
    row = '0;
    for (k = 0; k < MAX_BUTTONS; k++) begin
      ev = EV_NONE;
      if (k < N_BUTTONS) begin
        pressed = !lv[k];
        if (window_q[k] != 0) window_q[k] = window_q[k] - 1'b1;
        expired = (window_q[k] == 0);
        case (phase_q[k])
          ST_IDLE: begin
            if (pressed) begin
              window_q[k] = hold_cfg;
              phase_q[k] = ST_PRESS1;
            end
          end
          ST_PRESS1: begin
            if (expired) phase_q[k] = ST_HOLD;
            if (!pressed) phase_q[k] = ST_RELEASE1;
          end
          ST_RELEASE1: begin
            if (expired) begin
              ev = EV_SINGLE;
              phase_q[k] = ST_IDLE;
            end
            if (pressed) begin
              window_q[k] = hold_cfg;
              phase_q[k] = ST_PRESS2;
            end
          end
          ST_PRESS2: begin
            if (expired) phase_q[k] = ST_HOLD;
            if (!pressed) begin
              ev = EV_DOUBLE;
              phase_q[k] = ST_IDLE;
            end
          end
          ST_HOLD: begin
            if (!pressed) begin
              ev = EV_HOLD;
              phase_q[k] = ST_IDLE;
            end
          end
          default: ;
        endcase
      end
      row[2*k +: 2] = ev;
    end
    return row;
  endfunction

  // driver: predicts on each accepted tick, then loads the next one
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      clicks_due.push_back(classify_tick(levels_n_i));
      ticks_sent++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (tick_queue.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        levels_n_i <= tick_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    click_row_t got, want;
    int k;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '0;
      got[1:0] = click_btn0_o;
      got[3:2] = click_btn1_o;
      got[5:4] = click_btn2_o;
      if (clicks_due.size() == 0) begin
        flag_mismatch($sformatf("result %h with no tick pending", got));
      end else begin
        want = clicks_due.pop_front();
        for (k = 0; k < MAX_BUTTONS; k++) begin
          if (got[2*k +: 2] !== want[2*k +: 2])
            flag_mismatch($sformatf("button %0d: got %0d, want %0d",
                                    k, got[2*k +: 2], want[2*k +: 2]));
          ev_seen[want[2*k +: 2]]++;
        end
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < 31);
  end

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_HOLD_TICKS) hold_cfg = data[HOLD_W-1:0];
  endtask

  task automatic check_hold_readback;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_HOLD_TICKS;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[HOLD_W-1:0] !== hold_cfg)
      flag_mismatch($sformatf("hold_ticks read %0d, want %0d", prdata[HOLD_W-1:0], hold_cfg));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain;
    int waited;
    waited = 0;
    while ((tick_queue.size() != 0 || in_valid_i || clicks_due.size() != 0) && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (clicks_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", clicks_due.size()));
    clicks_due.delete();
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int pick_run(input int h);
    int r;
    if (h < 1) h = 1;
    r = $urandom_range(99);
    if (r < 35) return $urandom_range(h, 1);
    if (r < 60) return (h > 1) ? $urandom_range(h + 1, h - 1) : $urandom_range(2, 1);
    if (r < 85) return $urandom_range(2 * h + 2, h + 1);
    return $urandom_range(3, 1);
  endfunction

  // well-formed press/release runs per button, with some noise ticks mixed in
  task automatic run_phase(input logic [APB_DW-1:0] cfg, input int n, input logic quiet);
    logic [LEVEL_W-1:0] lv;
    int run_left [MAX_BUTTONS];
    int i, k;
    apb_write(ADDR_HOLD_TICKS, cfg);
    check_hold_readback();
    settings_run++;
    calm = quiet;
    lv = '1;
    for (k = 0; k < MAX_BUTTONS; k++) run_left[k] = pick_run(hold_cfg);
    for (i = 0; i < n; i++) begin
      for (k = 0; k < MAX_BUTTONS; k++) begin
        if (run_left[k] == 0) begin
          lv[k] = ~lv[k];
          run_left[k] = pick_run(hold_cfg);
        end
        run_left[k]--;
      end
      tick_queue.push_back(($urandom_range(99) < 10) ? LEVEL_W'($urandom_range(7)) : lv);
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    int k;
    hold_cfg = HOLD_TICKS_RST;
    for (k = 0; k < MAX_BUTTONS; k++) begin
      phase_q[k] = ST_IDLE;
      window_q[k] = '0;
    end
    for (k = 0; k < 4; k++) ev_seen[k] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset window of 6: single on btn0, double on btn1, hold on btn2, all pressed
    tick_queue = '{3'b111,
                   3'b110, 3'b110, 3'b111, 3'b111, 3'b111, 3'b111, 3'b111, 3'b111,
                   3'b101, 3'b111, 3'b101, 3'b111,
                   3'b011, 3'b011, 3'b011, 3'b011, 3'b011, 3'b011, 3'b011, 3'b111,
                   3'b000, 3'b000, 3'b111};
    drain();
    check_hold_readback();

    // writes outside register 0 are dropped
    apb_write(ADDR_UNMAPPED, $urandom);
    check_hold_readback();

    run_phase(32'd1, 100, 1'b0);
    run_phase(32'd0, 100, 1'b0);
    run_phase(32'hFFFF_FF03, 100, 1'b0);
    run_phase(32'd6, 100, 1'b1);
    run_phase(32'd255, 300, 1'b0);
    run_phase({8'($urandom_range(255)), 24'h0} | 32'($urandom_range(12, 1)), 100, 1'b0);
    run_phase(32'($urandom_range(40, 1)), 100, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    $display("%0d ticks over %0d hold_ticks settings; clicks seen: %0d single, %0d double, %0d hold",
             ticks_sent, settings_run, ev_seen[EV_SINGLE], ev_seen[EV_DOUBLE], ev_seen[EV_HOLD]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
